[rtl/core/csv_field_splitter_defines.svh]
// ----------------------------------------------------------------------------
// csv_field_splitter_defines
// Assertion macros shared by the csv field splitter modules.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_SPLITTER_DEFINES_SVH
`define CSV_FIELD_SPLITTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CSVFS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csv field splitter check failed");

// next-cycle implication, disabled during reset
`define CSVFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csv field splitter check failed");

`endif

[rtl/core/csvfs_pkg.sv]
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the csv field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  localparam logic [7:0] Apostrophe     = 8'h27;
  localparam logic [7:0] DelimiterReset = 8'd44;
  localparam logic [7:0] QuoteReset     = 8'd34;

  localparam int QueueDepth = 4;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegDelimiter = 1'b0;
  localparam logic [CfgIdxW-1:0] RegQuote     = 1'b1;

  // one classified transaction: bytes to give out, then an optional marker
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] bcnt;
    logic       marker;
    logic       rec_end;
  } cmd_t;

endpackage

[rtl/core/csvfs_front.sv]
// ----------------------------------------------------------------------------
// csvfs_front
// Accepts record bytes, tracks quote state and classifies each transaction
// into a command for the output sequencer.
// ----------------------------------------------------------------------------
module csvfs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [csvfs_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [csvfs_pkg::CfgDataW-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,
  input  logic [0:0]                        s_tuser,
  input  logic                              q_full,
  output logic                              push,
  output csvfs_pkg::cmd_t                   cmd
);
  import csvfs_pkg::*;

  logic [7:0] delimiter_char;
  logic [7:0] quote_char;
  logic       quote_parity, quote_parity_next;
  logic       at_field_start, at_field_start_next;
  logic       field_quoted, field_quoted_next;
  logic       pending_valid, pending_valid_next;
  logic [7:0] pending_byte, pending_byte_next;
  logic       accept;
  logic       is_q;
  logic       is_d;
  logic       par_n;
  cmd_t       cmd_next;

  function automatic cmd_t make_cmd(logic [7:0] b, logic has, logic mk, logic re);
    cmd_t c;
    c.data    = b;
    c.bcnt    = has ? ((b == Apostrophe) ? 2'd2 : 2'd1) : 2'd0;
    c.marker  = mk;
    c.rec_end = re;
    return c;
  endfunction

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_q     = (s_tdata == quote_char);
  assign is_d     = (s_tdata == delimiter_char);
  assign par_n    = quote_parity ^ is_q;

  always_comb begin
    quote_parity_next   = quote_parity;
    at_field_start_next = at_field_start;
    field_quoted_next   = field_quoted;
    pending_valid_next  = pending_valid;
    pending_byte_next   = pending_byte;
    cmd_next            = make_cmd(8'd0, 1'b0, 1'b0, 1'b0);
    if (accept) begin
      if (s_tuser[0] || (is_d && !is_q && !par_n)) begin
        cmd_next = make_cmd(pending_byte, pending_valid && (pending_byte != quote_char),
                            1'b1, s_tuser[0]);
        quote_parity_next   = 1'b0;
        at_field_start_next = 1'b1;
        field_quoted_next   = 1'b0;
        pending_valid_next  = 1'b0;
        pending_byte_next   = 8'd0;
      end else begin
        quote_parity_next = par_n;
        if (at_field_start) begin
          at_field_start_next = 1'b0;
          if (is_q) begin
            field_quoted_next = 1'b1;
          end else begin
            cmd_next = make_cmd(s_tdata, 1'b1, 1'b0, 1'b0);
          end
        end else if (field_quoted) begin
          cmd_next           = make_cmd(pending_byte, pending_valid, 1'b0, 1'b0);
          pending_byte_next  = s_tdata;
          pending_valid_next = 1'b1;
        end else begin
          cmd_next = make_cmd(s_tdata, 1'b1, 1'b0, 1'b0);
        end
      end
    end
  end

  assign cmd  = cmd_next;
  assign push = accept && (cmd_next.marker || (cmd_next.bcnt != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= DelimiterReset;
      quote_char     <= QuoteReset;
      quote_parity   <= 1'b0;
      at_field_start <= 1'b1;
      field_quoted   <= 1'b0;
      pending_valid  <= 1'b0;
      pending_byte   <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegDelimiter: delimiter_char <= cfg_data[7:0];
          RegQuote:     quote_char     <= cfg_data[7:0];
          default:      ;
        endcase
      end
      quote_parity   <= quote_parity_next;
      at_field_start <= at_field_start_next;
      field_quoted   <= field_quoted_next;
      pending_valid  <= pending_valid_next;
      pending_byte   <= pending_byte_next;
    end
  end

endmodule

[rtl/core/csvfs_queue.sv]
// ----------------------------------------------------------------------------
// csvfs_queue
// Short command queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module csvfs_queue #(
  parameter int Depth = csvfs_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csvfs_pkg::cmd_t wr_cmd,
  output logic            full,
  input  logic            pop,
  output csvfs_pkg::cmd_t rd_cmd,
  output logic            empty
);
  import csvfs_pkg::*;
  `include "csv_field_splitter_defines.svh"

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CSVFS_ASSERT_NOW(a_no_push_full, clk, rst, push, !full)
  `CSVFS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= FullCnt)
  `CSVFS_ASSERT_NEXT(a_push_fills, clk, rst, do_push && !do_pop, !empty)

endmodule

[rtl/core/csvfs_back.sv]
// ----------------------------------------------------------------------------
// csvfs_back
// Expands queued commands into result transactions, one per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module csvfs_back (
  input  logic            clk,
  input  logic            rst,
  input  csvfs_pkg::cmd_t q_cmd,
  input  logic            q_empty,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);
  import csvfs_pkg::*;
  `include "csv_field_splitter_defines.svh"

  logic [7:0] cur_byte;
  logic [1:0] cur_bcnt;
  logic       cur_mk;
  logic       cur_re;
  logic       cur_empty;
  logic       out_free;
  logic       out_load;
  logic       last_unit;

  assign cur_empty = (cur_bcnt == 2'd0) && !cur_mk;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && !cur_empty;
  assign last_unit = ((cur_bcnt == 2'd1) && !cur_mk) || ((cur_bcnt == 2'd0) && cur_mk);
  assign pop       = (cur_empty || (out_load && last_unit)) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bcnt <= 2'd0;
      cur_mk   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        if (cur_bcnt != 2'd0) begin
          m_tdata <= cur_byte;
          m_tuser <= 2'b01;
          m_tlast <= 1'b0;
        end else begin
          m_tdata <= 8'd0;
          m_tuser <= 2'b10;
          m_tlast <= cur_re;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        cur_byte <= q_cmd.data;
        cur_bcnt <= q_cmd.bcnt;
        cur_mk   <= q_cmd.marker;
        cur_re   <= q_cmd.rec_end;
      end else if (out_load) begin
        if (cur_bcnt != 2'd0) begin
          cur_bcnt <= cur_bcnt - 2'd1;
        end else begin
          cur_mk <= 1'b0;
        end
      end
    end
  end

  `CSVFS_ASSERT_NOW(a_marker_no_byte, clk, rst, m_tvalid && m_tuser[1],
                    !m_tuser[0] && (m_tdata == 8'd0))
  `CSVFS_ASSERT_NOW(a_last_on_marker, clk, rst, m_tvalid && m_tlast, m_tuser[1])
  `CSVFS_ASSERT_NOW(a_pop_when_done, clk, rst, pop && !cur_empty, out_load && last_unit)

endmodule

[rtl/core/csv_field_splitter.sv]
// Datapath: command queue, current-command register, then the output register.
// Throughput: one result per cycle at the output register while m_tready
// holds and commands are queued; an item gives 0 to 3 results.
// Input is taken every cycle while the 4-entry command queue has room.
// Reset (rst, synchronous): registers return to comma and double quote,
// field state to start of field, queue and output empty.
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a byte stream of CSV records into field bytes with field and record
// end markers, handling enclosing quotes and apostrophe doubling.
// ----------------------------------------------------------------------------
module csv_field_splitter #(
  parameter int QueueDepth = csvfs_pkg::QueueDepth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [csvfs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [csvfs_pkg::CfgDataW-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic [0:0]                     s_tuser,   // [0] opcode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic [1:0]                     m_tuser,   // [0] has_byte, [1] field_end
  output logic                           m_tlast    // record_end
);
  import csvfs_pkg::*;

  cmd_t wr_cmd;
  cmd_t rd_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  csvfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .cmd       (wr_cmd)
  );

  csvfs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .empty  (q_empty)
  );

  csvfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_cmd    (rd_cmd),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
